// ----- rtl/cvss_pkg.sv -----
// Shared types, constants and helper functions of the convex vertex support search block.
`default_nettype none

package cvss_pkg;

  // Store depth and the widths that follow from it
  localparam int MAX_VERTICES = 256;
  localparam int ADDR_W       = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int COUNT_W      = $clog2(MAX_VERTICES + 1);
  localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_VERTICES);

  // Field widths fixed by the interface
  localparam int COORD_W  = 32;
  localparam int CFG_IDX_W = 2;
  localparam int INDEX_W  = 8;
  localparam int VCOUNT_W = 9;

  // Request kinds
  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE_X = 2'd0,
    CFG_SCALE_Y = 2'd1,
    CFG_SCALE_Z = 2'd2,
    CFG_MARGIN  = 2'd3
  } cfg_idx_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COORD_W:0]   opnd_t;   // signed coord or unsigned scale
  typedef logic signed [64:0]        prod_t;
  typedef logic signed [66:0]        sum_t;
  typedef logic signed [65:0]        wide_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec_t;

  // Operands of the shared multiply unit
  typedef struct packed {
    vec_t  a;
    opnd_t bx;
    opnd_t by;
    opnd_t bz;
  } mac_in_t;

  typedef struct packed {
    prod_t x;
    prod_t y;
    prod_t z;
  } prod3_t;

  // Store write port
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    vec_t              data;
  } store_wr_t;

  // Clamp a wide signed value to the 32 bit range
  function automatic coord_t sat32(wide_t v);
    coord_t r;
    if (!v[65] && (|v[64:31])) begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end else if (v[65] && !(&v[64:31])) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Q32.32 product floored to Q16.16, offset, then clamped
  function automatic coord_t scale_out(prod_t p, wide_t off);
    wide_t s;
    s = 66'(p >>> 16) + off;
    return sat32(s);
  endfunction

  function automatic vec_t vmin(vec_t a, vec_t b);
    vec_t r;
    r.x = (b.x < a.x) ? b.x : a.x;
    r.y = (b.y < a.y) ? b.y : a.y;
    r.z = (b.z < a.z) ? b.z : a.z;
    return r;
  endfunction

  function automatic vec_t vmax(vec_t a, vec_t b);
    vec_t r;
    r.x = (b.x > a.x) ? b.x : a.x;
    r.y = (b.y > a.y) ? b.y : a.y;
    r.z = (b.z > a.z) ? b.z : a.z;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/cvss_req_if.sv -----
// Request channel: add a vertex or query the support vertex for a direction.
`default_nettype none

interface cvss_req_if;
  logic                   valid;
  logic                   ready;
  logic                   req_type;
  cvss_pkg::coord_t       coord_x;
  cvss_pkg::coord_t       coord_y;
  cvss_pkg::coord_t       coord_z;

  modport source (output valid, output req_type, output coord_x, output coord_y,
                  output coord_z, input ready);
  modport sink   (input valid, input req_type, input coord_x, input coord_y,
                  input coord_z, output ready);
endinterface

`default_nettype wire

// ----- rtl/cvss_rsp_if.sv -----
// Response channel: status, support vertex, scaled bounds and vertex count.
`default_nettype none

interface cvss_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          status;
  logic [cvss_pkg::INDEX_W-1:0]        support_index;
  cvss_pkg::coord_t                    support_x;
  cvss_pkg::coord_t                    support_y;
  cvss_pkg::coord_t                    support_z;
  cvss_pkg::coord_t                    low_bound_x;
  cvss_pkg::coord_t                    low_bound_y;
  cvss_pkg::coord_t                    low_bound_z;
  cvss_pkg::coord_t                    high_bound_x;
  cvss_pkg::coord_t                    high_bound_y;
  cvss_pkg::coord_t                    high_bound_z;
  logic [cvss_pkg::VCOUNT_W-1:0]       vertex_count;

  modport source (output valid, output status, output support_index, output support_x,
                  output support_y, output support_z, output low_bound_x,
                  output low_bound_y, output low_bound_z, output high_bound_x,
                  output high_bound_y, output high_bound_z, output vertex_count,
                  input ready);
  modport sink   (input valid, input status, input support_index, input support_x,
                  input support_y, input support_z, input low_bound_x,
                  input low_bound_y, input low_bound_z, input high_bound_x,
                  input high_bound_y, input high_bound_z, input vertex_count,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/cvss_cfg_if.sv -----
// Configuration write channel: register index and write data.
`default_nettype none

interface cvss_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [cvss_pkg::CFG_IDX_W-1:0]  index;
  logic [31:0]                     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/cvss_store.sv -----
// Vertex store: one write port, one read port with registered read data.
`default_nettype none

module cvss_store (
  input  wire                          clk,
  input  cvss_pkg::store_wr_t          wr,
  input  wire [cvss_pkg::ADDR_W-1:0]   rd_addr,
  output cvss_pkg::vec_t               rd_data
);

  cvss_pkg::vec_t mem [cvss_pkg::MAX_VERTICES];

  // Write at the fill point, read every cycle
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- rtl/cvss_mac.sv -----
// Shared multiply unit: three registered 32x33 products and their registered sum.
`default_nettype none

module cvss_mac (
  input  wire                 clk,
  input  cvss_pkg::mac_in_t   op,
  output cvss_pkg::prod3_t    prod,
  output cvss_pkg::sum_t      sum
);

  // Stage 1: per-axis products
  always_ff @(posedge clk) begin
    prod.x <= $signed(op.a.x) * $signed(op.bx);
    prod.y <= $signed(op.a.y) * $signed(op.by);
    prod.z <= $signed(op.a.z) * $signed(op.bz);
  end

  // Stage 2: dot product
  always_ff @(posedge clk) begin
    sum <= 67'(prod.x) + 67'(prod.y) + 67'(prod.z);
  end

endmodule

`default_nettype wire

// ----- rtl/convex_vertex_support_search.sv -----
// Top level: sequencer around the vertex store and the shared multiply unit.
//
// Channels: req (sink) carries add or query beats, rsp (source) returns one
// result beat per request, cfg (sink) writes scale_x/y/z and margin; cfg is
// always ready; the user must write cfg only while the block is idle, as
// the block does not enforce it. An add beat, if the store has room, stores
// the vertex and updates the corner registers; every add reports the scaled
// bounds. A query beat streams every stored vertex through the multiply
// unit, one vertex per cycle, keeping the first largest dot product, then
// scales the winner and the bounds on the same unit. The scan of a query
// is paced by the single read port of the store (one vertex read per
// cycle). req is ready only while the sequencer is idle, so one request is
// in flight at a time.
// The result sits in an output register; when rsp is stalled the block still
// takes the next request and holds the new result internally until the
// output register frees up.
// Reset (synchronous, active high) empties the store, clears the corners to
// zero, sets scales to 1.0 and margin to 0. Store contents need no clearing.
`default_nettype none

module convex_vertex_support_search (
  input  wire         clk,
  input  wire         rst,
  cvss_req_if.sink    req,
  cvss_rsp_if.source  rsp,
  cvss_cfg_if.sink    cfg
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DRAIN  = 5'b00100,
    S_SCALE  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state;

  // Configuration registers
  logic [31:0] scale_x, scale_y, scale_z;
  logic [30:0] margin;

  // Block state
  logic [cvss_pkg::COUNT_W-1:0] count;
  cvss_pkg::vec_t               min_c, max_c;

  // Query context
  cvss_pkg::vec_t               dir;
  cvss_pkg::status_t            status;
  logic                         sup_zero;
  logic [cvss_pkg::ADDR_W-1:0]  scan_addr;
  logic [cvss_pkg::ADDR_W-1:0]  idx1, idx2, idx3;
  logic                         v1, v2, v3;
  cvss_pkg::vec_t               vert2, vert3;
  logic                         have_best;
  cvss_pkg::sum_t               best_sum;
  cvss_pkg::vec_t               best_v;
  logic [cvss_pkg::ADDR_W-1:0]  best_idx;
  logic [1:0]                   sstep;
  cvss_pkg::vec_t               sup_s, lo_s, hi_s;

  // Output register
  logic                             rsp_valid;
  cvss_pkg::status_t                rsp_status;
  logic [cvss_pkg::INDEX_W-1:0]     rsp_index;
  cvss_pkg::vec_t                   rsp_sup, rsp_lo, rsp_hi;
  logic [cvss_pkg::VCOUNT_W-1:0]    rsp_count;

  // Datapath wiring
  cvss_pkg::store_wr_t  wr;
  cvss_pkg::vec_t       rd_data;
  cvss_pkg::mac_in_t    mac_in;
  cvss_pkg::prod3_t     prod;
  cvss_pkg::sum_t       dot_sum;
  logic                 accept;
  logic                 is_full;
  logic                 scan_last;
  logic                 better;
  cvss_pkg::wide_t      off;
  cvss_pkg::vec_t       cap_vec;
  cvss_pkg::vec_t       in_vec;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign is_full   = (count == cvss_pkg::MAX_COUNT);
  assign in_vec    = '{x: req.coord_x, y: req.coord_y, z: req.coord_z};
  assign scan_last = ((cvss_pkg::COUNT_W'(scan_addr) + cvss_pkg::COUNT_W'(1)) == count);
  assign better    = !have_best || (dot_sum > best_sum);

  // Store write on an accepted add
  always_comb begin
    wr.en   = accept && (req.req_type == cvss_pkg::REQ_ADD) && !is_full;
    wr.addr = count[cvss_pkg::ADDR_W-1:0];
    wr.data = in_vec;
  end

  cvss_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (scan_addr),
    .rd_data (rd_data)
  );

  // Operand select: dot products while scanning, scaling afterwards
  always_comb begin
    mac_in.a  = dir;
    mac_in.bx = {rd_data.x[31], rd_data.x};
    mac_in.by = {rd_data.y[31], rd_data.y};
    mac_in.bz = {rd_data.z[31], rd_data.z};
    if (state == S_SCALE) begin
      case (sstep)
        2'd0:    mac_in.a = best_v;
        2'd1:    mac_in.a = min_c;
        default: mac_in.a = max_c;
      endcase
      mac_in.bx = {1'b0, scale_x};
      mac_in.by = {1'b0, scale_y};
      mac_in.bz = {1'b0, scale_z};
    end
  end

  cvss_mac u_mac (
    .clk  (clk),
    .op   (mac_in),
    .prod (prod),
    .sum  (dot_sum)
  );

  // Finish a scaled product: margin off the low bound, onto the high bound
  always_comb begin
    case (sstep)
      2'd2:    off = -$signed({35'd0, margin});
      2'd3:    off = $signed({35'd0, margin});
      default: off = '0;
    endcase
    cap_vec.x = cvss_pkg::scale_out(prod.x, off);
    cap_vec.y = cvss_pkg::scale_out(prod.y, off);
    cap_vec.z = cvss_pkg::scale_out(prod.z, off);
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_x <= 32'd65536;
      scale_y <= 32'd65536;
      scale_z <= 32'd65536;
      margin  <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        cvss_pkg::CFG_SCALE_X: scale_x <= cfg.data;
        cvss_pkg::CFG_SCALE_Y: scale_y <= cfg.data;
        cvss_pkg::CFG_SCALE_Z: scale_z <= cfg.data;
        cvss_pkg::CFG_MARGIN:  margin  <= cfg.data[30:0];
        default: ;
      endcase
    end
  end

  // Scan pipeline payload: read data, then product, then sum
  always_ff @(posedge clk) begin
    idx1  <= scan_addr;
    idx2  <= idx1;
    idx3  <= idx2;
    vert2 <= rd_data;
    vert3 <= vert2;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      min_c     <= '0;
      max_c     <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      have_best <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      v1 <= (state == S_SCAN);
      v2 <= v1;
      v3 <= v2;

      // output beat taken and nothing reloads it this cycle
      if (rsp_valid && rsp.ready && (state != S_FINISH)) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            best_idx  <= '0;
            sup_zero  <= 1'b1;
            sstep     <= '0;
            scan_addr <= '0;
            have_best <= 1'b0;
            dir       <= in_vec;
            state     <= S_SCALE;
            if (req.req_type == cvss_pkg::REQ_ADD) begin
              if (is_full) begin
                status <= cvss_pkg::ST_FULL;
              end else begin
                status <= cvss_pkg::ST_OK;
                count  <= count + cvss_pkg::COUNT_W'(1);
                min_c  <= cvss_pkg::vmin(min_c, in_vec);
                max_c  <= cvss_pkg::vmax(max_c, in_vec);
              end
            end else if (count == '0) begin
              status <= cvss_pkg::ST_EMPTY;
            end else begin
              status   <= cvss_pkg::ST_OK;
              sup_zero <= 1'b0;
              state    <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // one store read per cycle
          if (scan_last) begin
            state <= S_DRAIN;
          end else begin
            scan_addr <= scan_addr + cvss_pkg::ADDR_W'(1);
          end
        end
        S_DRAIN: begin
          if (!v1 && !v2 && !v3) begin
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          case (sstep)
            2'd1:    sup_s <= cap_vec;
            2'd2:    lo_s  <= cap_vec;
            2'd3:    hi_s  <= cap_vec;
            default: ;
          endcase
          if (sstep == 2'd3) begin
            state <= S_FINISH;
          end
          sstep <= sstep + 2'd1;
        end
        S_FINISH: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid  <= 1'b1;
            rsp_status <= status;
            rsp_index  <= cvss_pkg::INDEX_W'(best_idx);
            rsp_sup    <= sup_zero ? '0 : sup_s;
            rsp_lo     <= lo_s;
            rsp_hi     <= hi_s;
            rsp_count  <= cvss_pkg::VCOUNT_W'(count);
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      // Keep the first largest dot product
      if (v3 && better) begin
        have_best <= 1'b1;
        best_sum  <= dot_sum;
        best_v    <= vert3;
        best_idx  <= idx3;
      end
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.status        = rsp_status;
  assign rsp.support_index = rsp_index;
  assign rsp.support_x     = rsp_sup.x;
  assign rsp.support_y     = rsp_sup.y;
  assign rsp.support_z     = rsp_sup.z;
  assign rsp.low_bound_x   = rsp_lo.x;
  assign rsp.low_bound_y   = rsp_lo.y;
  assign rsp.low_bound_z   = rsp_lo.z;
  assign rsp.high_bound_x  = rsp_hi.x;
  assign rsp.high_bound_y  = rsp_hi.y;
  assign rsp.high_bound_z  = rsp_hi.z;
  assign rsp.vertex_count  = rsp_count;

`ifndef SYNTHESIS
  // The fill count never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= cvss_pkg::MAX_COUNT)
    else $error("vertex count beyond store depth");

  // Scan reads only written entries
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (cvss_pkg::COUNT_W'(scan_addr) < count))
    else $error("scan address beyond stored vertices");

  // A reported support vertex is a stored one
  a_best_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && !sup_zero) |-> (cvss_pkg::COUNT_W'(best_idx) < count))
    else $error("support index beyond stored vertices");

  // A finished result waits while the output register is blocked
  a_finish_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && rsp_valid && !rsp.ready) |=> (state == S_FINISH))
    else $error("result dropped while output stalled");
`endif

endmodule

`default_nettype wire
